/* design/zcws_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zcws_pkg
// Shared widths, defaults and the queue word type of the wave segmenter.
// ---------------------------------------------------------------------------
package zcws_pkg;
	localparam int TimeWidthDef   = 32;
	localparam int SampleWidthDef = 16;
	localparam int FracBitsDef    = 8;
	localparam int QBits          = 8;
	localparam int TW   = TimeWidthDef;
	localparam int SW   = SampleWidthDef;
	localparam int FB   = FracBitsDef;
	localparam int ZW   = TW + FB;
	localparam int AW   = SW;        // magnitude width, holds 2^(SW-1)
	localparam int SUMW = SW + 1;    // |e1| + |e2|

	// front to back: one crossing word
	typedef struct packed {
		logic          emit;
		logic          kind;
		logic [ZW-1:0] start_t;
		logic [ZW-1:0] mid_t;
		logic [TW-1:0] t1;
		logic [TW-1:0] dt;
		logic [AW-1:0] mag_a;
		logic [SUMW-1:0] mag_s;
		logic [SW-2:0] crest;
		logic [TW-1:0] crest_time;
		logic [SW-1:0] depth;
		logic [TW-1:0] trough_time;
	} xing_t;
endpackage

/* design/zcws_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zcws_front
// Detects sign changes, tracks half-wave extremes and queues crossing words.
// The zero time of each crossing is fed back from the back end in order.
// ---------------------------------------------------------------------------
module zcws_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [zcws_pkg::TW-1:0]  sample_time,
	input  logic signed [zcws_pkg::SW-1:0] elevation,
	output logic                     q_valid,
	input  logic                     q_pop,
	output zcws_pkg::xing_t          q_word,
	input  logic                     z_valid,
	input  logic [zcws_pkg::ZW-1:0]  z_time
);
	import zcws_pkg::*;

	logic [TW-1:0] last_time_q;
	logic signed [SW-1:0] last_elev_q;
	logic last_valid_q;
	logic [1:0] seen_q;
	logic [ZW-1:0] older_z_q, newer_z_q;
	logic older_k_q, newer_k_q;
	logic signed [SW-1:0] pmax_q, pmin_q, rmax_q, rmin_q;
	logic [TW-1:0] pmax_t_q, pmin_t_q, rmax_t_q, rmin_t_q;
	logic z_pend_q;
	xing_t word_q;
	logic full_q;

	logic acc, xing;
	logic [AW-1:0] ma, mb;
	logic signed [SW-1:0] crest, low;
	logic [TW-1:0] crest_t, low_t;
	logic signed [SW:0] neg_low;

	// hold input while queue full or a zero time is still owed
	assign in_stall = full_q | z_pend_q;
	assign acc = in_valid & ~in_stall;
	assign xing = last_valid_q & (((last_elev_q > 0) && (elevation < 0)) ||
		((last_elev_q < 0) && (elevation > 0)));
	assign ma = last_elev_q[SW-1] ? AW'(-last_elev_q) : AW'(last_elev_q);
	assign mb = elevation[SW-1] ? AW'(-elevation) : AW'(elevation);

	always_comb begin
		crest = pmax_q; crest_t = pmax_t_q;
		low = pmin_q; low_t = pmin_t_q;
		if (rmax_q > crest) begin
			crest = rmax_q; crest_t = rmax_t_q;
		end
		if (rmin_q < low) begin
			low = rmin_q; low_t = rmin_t_q;
		end
		neg_low = -{low[SW-1], low};
	end

	assign q_valid = full_q;
	assign q_word = word_q;

	// one-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (acc && xing) begin
			full_q <= 1'b1;
		end else if (q_pop) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && xing) begin
			word_q.emit        <= seen_q[1];
			word_q.kind        <= older_k_q;
			word_q.start_t     <= older_z_q;
			word_q.mid_t       <= newer_z_q;
			word_q.t1          <= last_time_q;
			word_q.dt          <= sample_time - last_time_q;
			word_q.mag_a       <= ma;
			word_q.mag_s       <= SUMW'(ma) + SUMW'(mb);
			word_q.crest       <= crest[SW-2:0];
			word_q.crest_time  <= crest_t;
			word_q.depth       <= neg_low[SW-1:0];
			word_q.trough_time <= low_t;
		end
	end

	// advance tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0; last_elev_q <= '0; last_valid_q <= 1'b0;
			seen_q <= '0; older_z_q <= '0; newer_z_q <= '0;
			older_k_q <= 1'b0; newer_k_q <= 1'b0; z_pend_q <= 1'b0;
			pmax_q <= '0; pmin_q <= '0; rmax_q <= '0; rmin_q <= '0;
			pmax_t_q <= '0; pmin_t_q <= '0; rmax_t_q <= '0; rmin_t_q <= '0;
		end else begin
			if (z_valid) begin
				newer_z_q <= z_time;
				z_pend_q <= 1'b0;
			end
			if (acc) begin
				if (xing) begin
					z_pend_q <= 1'b1;
					older_z_q <= newer_z_q;
					older_k_q <= newer_k_q;
					newer_k_q <= last_elev_q[SW-1];
					pmax_q <= rmax_q; pmax_t_q <= rmax_t_q;
					pmin_q <= rmin_q; pmin_t_q <= rmin_t_q;
					if (!seen_q[1]) begin
						seen_q <= seen_q + 2'd1;
					end
					if (elevation > 0) begin
						rmax_q <= elevation; rmax_t_q <= sample_time;
					end else begin
						rmax_q <= '0; rmax_t_q <= '0;
					end
					if (elevation < 0) begin
						rmin_q <= elevation; rmin_t_q <= sample_time;
					end else begin
						rmin_q <= '0; rmin_t_q <= '0;
					end
				end else begin
					if (elevation > rmax_q) begin
						rmax_q <= elevation; rmax_t_q <= sample_time;
					end
					if (elevation < rmin_q) begin
						rmin_q <= elevation; rmin_t_q <= sample_time;
					end
				end
				last_time_q <= sample_time;
				last_elev_q <= elevation;
				last_valid_q <= 1'b1;
			end
		end
	end
endmodule

/* design/zcws_divider.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zcws_divider
// Restoring divider, one quotient bit per cycle: quotient = num / den.
// ---------------------------------------------------------------------------
module zcws_divider #(
	parameter int NW = 48,
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], n_q[NW-1]};
	assign quo = n_q;

	// shift and subtract one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; cnt_q <= '0;
			n_q <= '0; r_q <= '0; d_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; n_q <= num; d_q <= den; r_q <= '0;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				if (trial >= {1'b0, d_q}) begin
					r_q <= trial - {1'b0, d_q};
					n_q <= {n_q[NW-2:0], 1'b1};
				end else begin
					r_q <= trial;
					n_q <= {n_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end
endmodule

/* design/zcws_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zcws_back
// Interpolates the zero time, computes both asymmetries on a shared divider
// and holds the wave record in an output register.
// ---------------------------------------------------------------------------
module zcws_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  zcws_pkg::xing_t         q_word,
	output logic                    z_valid,
	output logic [zcws_pkg::ZW-1:0] z_time,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    wave_kind,
	output logic [zcws_pkg::ZW-1:0] start_zero_time,
	output logic [zcws_pkg::ZW-1:0] middle_zero_time,
	output logic [zcws_pkg::ZW-1:0] end_zero_time,
	output logic [zcws_pkg::SW-2:0] crest_amplitude,
	output logic [zcws_pkg::TW-1:0] crest_time,
	output logic [zcws_pkg::SW-1:0] trough_depth,
	output logic [zcws_pkg::TW-1:0] trough_time,
	output logic [zcws_pkg::SW-1:0] total_height,
	output logic [zcws_pkg::SW-1:0] vertical_asymmetry,
	output logic [zcws_pkg::SW-1:0] horizontal_asymmetry
);
	import zcws_pkg::*;

	localparam int NW = TW + SW + FB + QBits;   // numerator width, covers the widest numerator
	localparam int DW = ZW;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_MUL = 6'b000010, S_ZDIV = 6'b000100,
		S_VDIV = 6'b001000, S_HDIV = 6'b010000, S_OUT = 6'b100000
	} st_t;
	st_t st_q;

	xing_t w_q;
	logic [TW+AW+FB-1:0] prod_q;
	logic [ZW-1:0] z_q;
	logic [SW-1:0] vas_q;
	logic [SW-1:0] has_q;
	logic div_start;
	logic [NW-1:0] div_num, quo;
	logic [DW-1:0] div_den;
	logic div_done;
	logic [ZW-1:0] hnum, hden;

	zcws_divider #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(quo)
	);

	assign hnum = w_q.mid_t - w_q.start_t;
	assign hden = z_q - w_q.mid_t;
	assign q_pop = (st_q == S_IDLE) && q_valid;

	// saturate a Q8.8 quotient
	function automatic logic [SW-1:0] sat(input logic [NW-1:0] v, input logic dz);
		logic [SW-1:0] r;
		if (dz || (v[NW-1:SW] != '0)) r = '1;
		else r = v[SW-1:0];
		return r;
	endfunction

	always_comb begin
		div_start = 1'b0; div_num = '0; div_den = '0;
		unique case (st_q)
			S_MUL: begin
				div_start = 1'b1;
				div_num = NW'(prod_q);
				div_den = DW'(w_q.mag_s);
			end
			S_ZDIV: begin
				div_start = div_done && w_q.emit;
				div_num = NW'({w_q.crest, QBits'(0)});
				div_den = DW'(w_q.depth);
			end
			S_VDIV: begin
				div_start = div_done;
				div_num = NW'({hnum, QBits'(0)});
				div_den = hden;
			end
			default: ;
		endcase
	end

	// sequence one crossing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0; z_valid <= 1'b0;
		end else begin
			z_valid <= (st_q == S_ZDIV) && div_done;
			if (st_q == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_valid) st_q <= S_MUL;
				S_MUL: st_q <= S_ZDIV;
				S_ZDIV: if (div_done) st_q <= w_q.emit ? S_VDIV : S_IDLE;
				S_VDIV: if (div_done) st_q <= S_HDIV;
				S_HDIV: if (div_done) st_q <= S_OUT;
				S_OUT: if (!out_valid || !out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			w_q <= q_word;
			prod_q <= {q_word.dt, FB'(0)} * q_word.mag_a;
		end
		if (st_q == S_ZDIV && div_done) z_q <= {w_q.t1, FB'(0)} + quo[ZW-1:0];
		if (st_q == S_VDIV && div_done) vas_q <= sat(quo, w_q.depth == '0);
		if (st_q == S_HDIV && div_done) has_q <= sat(quo, hden == '0);
		if (st_q == S_OUT && (!out_valid || !out_stall)) begin
			wave_kind <= w_q.kind;
			start_zero_time <= w_q.start_t;
			middle_zero_time <= w_q.mid_t;
			end_zero_time <= z_q;
			crest_amplitude <= w_q.crest;
			crest_time <= w_q.crest_time;
			trough_depth <= w_q.depth;
			trough_time <= w_q.trough_time;
			total_height <= SW'(w_q.crest) + w_q.depth;
			vertical_asymmetry <= vas_q;
			horizontal_asymmetry <= has_q;
		end
	end

	assign z_time = z_q;
endmodule

/* design/zero_crossing_wave_segmenter_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zero_crossing_wave_segmenter_unit
// Splits an elevation stream into overlapping zero-crossing waves.
// ---------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       sink       in_valid/in_stall  sample_time, elevation
// out      source     out_valid/out_stall  wave record, eleven fields
//
// A sample without a crossing raises no stall of its own. A crossing holds the
// input until its zero time is known, mostly through the 64 steps of the
// shared bit-serial divider; a wave record needs two more divisions before
// out_valid is raised.
// Reset clears all tracking state; no clearing pass.
// A stalled output parks the back end; the front still takes samples until
// the next crossing.
module zero_crossing_wave_segmenter_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [zcws_pkg::TW-1:0] sample_time,
	input  logic signed [zcws_pkg::SW-1:0] elevation,
	output logic out_valid,
	input  logic out_stall,
	output logic wave_kind,
	output logic [zcws_pkg::ZW-1:0] start_zero_time,
	output logic [zcws_pkg::ZW-1:0] middle_zero_time,
	output logic [zcws_pkg::ZW-1:0] end_zero_time,
	output logic [zcws_pkg::SW-2:0] crest_amplitude,
	output logic [zcws_pkg::TW-1:0] crest_time,
	output logic [zcws_pkg::SW-1:0] trough_depth,
	output logic [zcws_pkg::TW-1:0] trough_time,
	output logic [zcws_pkg::SW-1:0] total_height,
	output logic [zcws_pkg::SW-1:0] vertical_asymmetry,
	output logic [zcws_pkg::SW-1:0] horizontal_asymmetry
);
	import zcws_pkg::*;

	logic q_valid, q_pop, z_valid;
	xing_t q_word;
	logic [ZW-1:0] z_time;

	zcws_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sample_time(sample_time), .elevation(elevation), .q_valid(q_valid),
		.q_pop(q_pop), .q_word(q_word), .z_valid(z_valid), .z_time(z_time)
	);

	zcws_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_word(q_word), .z_valid(z_valid), .z_time(z_time),
		.out_valid(out_valid), .out_stall(out_stall), .wave_kind(wave_kind),
		.start_zero_time(start_zero_time), .middle_zero_time(middle_zero_time),
		.end_zero_time(end_zero_time), .crest_amplitude(crest_amplitude),
		.crest_time(crest_time), .trough_depth(trough_depth),
		.trough_time(trough_time), .total_height(total_height),
		.vertical_asymmetry(vertical_asymmetry),
		.horizontal_asymmetry(horizontal_asymmetry)
	);
endmodule

/* test/zero_crossing_wave_segmenter_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zero_crossing_wave_segmenter_unit_test
// Drives timed elevation samples into the wave segmenter, predicts each
// overlapping zero-crossing wave record and compares it field by field.
// ---------------------------------------------------------------------------

// wave record as the block presents it
typedef struct {
	logic                      kind;
	logic [zcws_pkg::ZW-1:0]   start_t;
	logic [zcws_pkg::ZW-1:0]   mid_t;
	logic [zcws_pkg::ZW-1:0]   end_t;
	logic [zcws_pkg::SW-2:0]   crest;
	logic [zcws_pkg::TW-1:0]   crest_t;
	logic [zcws_pkg::SW-1:0]   depth;
	logic [zcws_pkg::TW-1:0]   trough_t;
	logic [zcws_pkg::SW-1:0]   height;
	logic [zcws_pkg::SW-1:0]   vasym;
	logic [zcws_pkg::SW-1:0]   hasym;
} wave_rec_t;

class wave_scoreboard;
	// tracking state of the segmenter
	logic [31:0] prev_t;
	int          prev_e;
	bit          prev_ok;
	int          n_cross;
	logic [39:0] zt_old, zt_new;
	bit          kind_old, kind_new;
	int          hi_prev, lo_prev, hi_run, lo_run;
	logic [31:0] hi_prev_t, lo_prev_t, hi_run_t, lo_run_t;
	wave_rec_t   pending[$];
	int          errors;

	function new();
		prev_t = 0; prev_e = 0; prev_ok = 0; n_cross = 0;
		zt_old = 0; zt_new = 0; kind_old = 0; kind_new = 0;
		hi_prev = 0; lo_prev = 0; hi_run = 0; lo_run = 0;
		hi_prev_t = 0; lo_prev_t = 0; hi_run_t = 0; lo_run_t = 0;
		errors = 0;
	endfunction

	// exact Q8.8 quotient, truncated, saturating
	function logic [15:0] q88(longint unsigned num, longint unsigned den);
		longint unsigned q;
		if (den == 0) return 16'hFFFF;
		q = (num << 8) / den;
		if (q > 64'hFFFF) return 16'hFFFF;
		return q[15:0];
	endfunction

	function void note_sample(logic [31:0] t, logic signed [15:0] el);
		int e, a, b;
		logic [31:0] dt;
		logic [39:0] z;
		logic [79:0] off;
		wave_rec_t w;
		int crest, low;
		logic [31:0] ct, lt;
		longint unsigned dep;
		e = el;
		if (prev_ok && ((prev_e > 0 && e < 0) || (prev_e < 0 && e > 0))) begin
			a = prev_e < 0 ? -prev_e : prev_e;
			b = e < 0 ? -e : e;
			dt = t - prev_t;
			off = ({48'd0, dt} * a << 8) / (a + b);
			z = {prev_t, 8'd0} + off[39:0];
			if (n_cross >= 2) begin
				crest = hi_prev; ct = hi_prev_t; low = lo_prev; lt = lo_prev_t;
				if (hi_run > crest) begin crest = hi_run; ct = hi_run_t; end
				if (lo_run < low) begin low = lo_run; lt = lo_run_t; end
				dep = -low;
				w.kind = kind_old; w.start_t = zt_old; w.mid_t = zt_new; w.end_t = z;
				w.crest = 15'(crest); w.crest_t = ct; w.depth = 16'(dep); w.trough_t = lt;
				w.height = 16'(crest + dep);
				w.vasym = q88(crest, dep);
				w.hasym = q88(40'(zt_new - zt_old), 40'(z - zt_new));
				pending.push_back(w);
			end
			zt_old = zt_new; kind_old = kind_new;
			zt_new = z; kind_new = prev_e < 0;
			hi_prev = hi_run; hi_prev_t = hi_run_t; lo_prev = lo_run; lo_prev_t = lo_run_t;
			hi_run = 0; hi_run_t = 0; lo_run = 0; lo_run_t = 0;
			if (n_cross < 2) n_cross++;
		end
		if (e > hi_run) begin hi_run = e; hi_run_t = t; end
		if (e < lo_run) begin lo_run = e; lo_run_t = t; end
		prev_t = t; prev_e = e; prev_ok = 1;
	endfunction

	function void check_wave(wave_rec_t g);
		wave_rec_t x;
		if (pending.size() == 0) begin
			$error("unexpected wave word");
			errors++;
			return;
		end
		x = pending.pop_front();
		if (g.kind !== x.kind) begin $error("wave_kind exp %0d got %0d", x.kind, g.kind); errors++; end
		if (g.start_t !== x.start_t) begin
			$error("start_zero_time exp %0h got %0h", x.start_t, g.start_t); errors++;
		end
		if (g.mid_t !== x.mid_t) begin
			$error("middle_zero_time exp %0h got %0h", x.mid_t, g.mid_t); errors++;
		end
		if (g.end_t !== x.end_t) begin
			$error("end_zero_time exp %0h got %0h", x.end_t, g.end_t); errors++;
		end
		if (g.crest !== x.crest) begin
			$error("crest_amplitude exp %0d got %0d", x.crest, g.crest); errors++;
		end
		if (g.crest_t !== x.crest_t) begin
			$error("crest_time exp %0h got %0h", x.crest_t, g.crest_t); errors++;
		end
		if (g.depth !== x.depth) begin
			$error("trough_depth exp %0d got %0d", x.depth, g.depth); errors++;
		end
		if (g.trough_t !== x.trough_t) begin
			$error("trough_time exp %0h got %0h", x.trough_t, g.trough_t); errors++;
		end
		if (g.height !== x.height) begin
			$error("total_height exp %0d got %0d", x.height, g.height); errors++;
		end
		if (g.vasym !== x.vasym) begin
			$error("vertical_asymmetry exp %0h got %0h", x.vasym, g.vasym); errors++;
		end
		if (g.hasym !== x.hasym) begin
			$error("horizontal_asymmetry exp %0h got %0h", x.hasym, g.hasym); errors++;
		end
	endfunction
endclass

module zero_crossing_wave_segmenter_unit_test;
	import zcws_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [TW-1:0] sample_time;
	logic signed [SW-1:0] elevation;
	logic wave_kind;
	logic [ZW-1:0] start_zero_time, middle_zero_time, end_zero_time;
	logic [SW-2:0] crest_amplitude;
	logic [TW-1:0] crest_time, trough_time;
	logic [SW-1:0] trough_depth, total_height, vertical_asymmetry, horizontal_asymmetry;

	wave_scoreboard waves = new();
	bit  idle_in_on = 1, idle_out_on = 1;
	int  hold_cycles = 0;
	logic [31:0] now_t = 0;
	logic signed [15:0] wave_sign = 1;

	zero_crossing_wave_segmenter_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// receiver: random stall, plus long hold-offs on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= idle_out_on && ($urandom_range(99) < 33);
		end
	end

	// check each accepted wave word
	always @(posedge clk) begin
		wave_rec_t g;
		if (arst_n && out_valid && !out_stall) begin
			g.kind = wave_kind; g.start_t = start_zero_time; g.mid_t = middle_zero_time;
			g.end_t = end_zero_time; g.crest = crest_amplitude; g.crest_t = crest_time;
			g.depth = trough_depth; g.trough_t = trough_time; g.height = total_height;
			g.vasym = vertical_asymmetry; g.hasym = horizontal_asymmetry;
			waves.check_wave(g);
		end
	end

	// offer one sample word and hold it until taken
	task automatic send_sample(logic [31:0] t, logic signed [15:0] e);
		while (idle_in_on && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_time <= t;
		elevation <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		waves.note_sample(t, e);
	endtask

	task automatic step_sample(int dt_max, logic signed [15:0] e);
		now_t = now_t + $urandom_range(dt_max);
		send_sample(now_t, e);
	endtask

	// random magnitude, mostly small, sometimes full scale
	function automatic int rand_mag();
		case ($urandom_range(9))
			0: return 32767;
			1: return $urandom_range(32767, 30000);
			2: return $urandom_range(3);
			default: return $urandom_range(32767, 1) >> $urandom_range(14);
		endcase
	endfunction

	// one half-wave of a given sign, a few samples long
	task automatic half_wave();
		int n, m;
		n = $urandom_range(4, 1);
		for (int i = 0; i < n; i++) begin
			m = rand_mag();
			if ($urandom_range(19) == 0) m = 0;
			step_sample($urandom_range(3) == 0 ? 32'hFFFF : 40,
				16'(wave_sign > 0 ? m : -m));
		end
		if (wave_sign > 0) begin
			step_sample(40, 16'($urandom_range(32767, 1)));
		end else begin
			step_sample(40, 16'(-$urandom_range(32768, 1)));
		end
		wave_sign = -wave_sign;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (waves.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		in_valid = 0; sample_time = 0; elevation = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero samples, wrapping time, equal halves
		send_sample(32'hFFFF_FFF0, 16'sd0);
		send_sample(32'hFFFF_FFF8, 16'sd32767);
		send_sample(32'h0000_0010, -16'sd32768);
		send_sample(32'h0000_0010, 16'sd1);
		send_sample(32'h0000_0020, 16'sd0);
		send_sample(32'h0000_0030, -16'sd1);
		send_sample(32'h0000_0040, 16'sd5);
		send_sample(32'h0000_0040, -16'sd5);
		send_sample(32'h0000_0050, 16'sd32767);
		send_sample(32'h0000_0060, 16'sd32767);
		send_sample(32'h8000_0000, -16'sd3);
		send_sample(32'h8000_0001, 16'sd3);
		send_sample(32'hFFFF_FFFF, -16'sd32768);
		send_sample(32'hFFFF_FFFF, 16'sd2);
		send_sample(32'h0000_0001, -16'sd1);
		send_sample(32'h5555_5555, 16'sd21845);
		send_sample(32'hAAAA_AAAA, -16'sd21846);
		send_sample(32'hAAAA_AAAB, 16'sd100);
		now_t = 32'hAAAA_AAAB;
		drain();

		// receiver holds off while the sender keeps offering samples
		hold_cycles = 3000;
		for (int i = 0; i < 40; i++) half_wave();
		drain();

		// long stretch with no idling on either side
		idle_in_on = 0; idle_out_on = 0;
		for (int i = 0; i < 120; i++) half_wave();
		idle_in_on = 1; idle_out_on = 1;

		// random: mostly well-formed waves, some noise
		for (int i = 0; i < 330; i++) begin
			if ($urandom_range(9) == 0) begin
				send_sample($urandom, 16'($urandom));
				now_t = $urandom;
			end else begin
				half_wave();
			end
		end
		drain();

		if (waves.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
